/* rtl/packed12_frame_stream_unpacker_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the packed 12-bit frame stream unpacker.
// Each macro expects clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef PACKED12_FRAME_STREAM_UNPACKER_ASSERT_SVH
`define PACKED12_FRAME_STREAM_UNPACKER_ASSERT_SVH

// same-cycle implication
`define PF12U_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pf12u check failed");

// next-cycle implication
`define PF12U_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pf12u check failed");

`endif

/* rtl/pf12u_pkg.sv */
// ---------------------------------------------------------------------------
// pf12u_pkg
// Shared types and codes of the packed 12-bit frame stream unpacker.
// ---------------------------------------------------------------------------
package pf12u_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned ERR_W   = 3;

  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_HEADER   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_ENCODING = 3'd2;
  localparam logic [ERR_W-1:0] ERR_FRAME_ID = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TICK_ID  = 3'd4;

  // configuration register indexes
  localparam logic CFG_FRAMES_TO_TAKE = 1'b0;
  localparam logic CFG_ENCODING_CODE  = 1'b1;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic [KIND_W-1:0]  item_kind;
    logic [VALUE_W-1:0] item_value;
    logic [ERR_W-1:0]   error_code;
    logic               end_of_frame;
    logic               last_of_run;
  } result_t;

endpackage

/* rtl/packed12_frame_stream_unpacker.sv */
// ---------------------------------------------------------------------------
// packed12_frame_stream_unpacker
// Parses a little-endian acquisition byte stream (header, frame blocks,
// tick blocks) and unpacks 12-bit packed pixels into result items.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   in_stream_byte
//   out_     out  out_valid / out_ready item_kind, item_value, error_code,
//                                       end_of_frame, last_of_run
//   cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle while the result queue has room; a byte is registered
// before the parser, and its results are written into the 4-entry queue.
// A byte triple gives two results, drained one per cycle while out_ready is
// high; the input stalls only while the queue holds more than two.
// Reset (rst_n low, synchronous) returns the parser to the header id.
// ---------------------------------------------------------------------------
module packed12_frame_stream_unpacker #(
  parameter int unsigned MAX_DIMENSION_BITS = 16,
  parameter int unsigned TICK_BYTES         = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_item_kind,
  output logic [63:0] out_item_value,
  output logic [2:0]  out_error_code,
  output logic        out_end_of_frame,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]        frames_to_take_r;
  logic [7:0]         encoding_code_r;
  logic               can_take;
  logic [1:0]         push_n;
  pf12u_pkg::result_t res0;
  pf12u_pkg::result_t res1;
  pf12u_pkg::result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_to_take_r <= 16'd1;
      encoding_code_r  <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pf12u_pkg::CFG_FRAMES_TO_TAKE: frames_to_take_r <= cfg_data;
        pf12u_pkg::CFG_ENCODING_CODE:  encoding_code_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  pf12u_parser #(
    .MAX_DIMENSION_BITS (MAX_DIMENSION_BITS),
    .TICK_BYTES         (TICK_BYTES)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_byte        (in_stream_byte),
    .in_ready       (in_ready),
    .can_take       (can_take),
    .frames_to_take (frames_to_take_r),
    .encoding_code  (encoding_code_r),
    .res0           (res0),
    .res1           (res1),
    .push_n         (push_n)
  );

  pf12u_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_item_kind    = out_res.item_kind;
  assign out_item_value   = out_res.item_value;
  assign out_error_code   = out_res.error_code;
  assign out_end_of_frame = out_res.end_of_frame;
  assign out_last_of_run  = out_res.last_of_run;

endmodule

/* rtl/pf12u_parser.sv */
// ---------------------------------------------------------------------------
// pf12u_parser
// Input byte register plus the stream parser: header, frame blocks, 12-bit
// pixel unpacking, padding skips and tick blocks. Emits up to two results.
// ---------------------------------------------------------------------------
module pf12u_parser #(
  parameter int unsigned MAX_DIMENSION_BITS = 16,
  parameter int unsigned TICK_BYTES         = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  output logic                  in_ready,
  input  logic                  can_take,
  input  logic [15:0]           frames_to_take,
  input  logic [7:0]            encoding_code,
  output pf12u_pkg::result_t    res0,
  output pf12u_pkg::result_t    res1,
  output logic [1:0]            push_n
);

  localparam int unsigned W  = MAX_DIMENSION_BITS;
  localparam int unsigned UW = 16 + W;

  typedef enum logic [3:0] {
    PH_HDR_ID, PH_HDR_LEN, PH_STRIDE, PH_ENC, PH_CLOCK, PH_WIDTH, PH_HEIGHT,
    PH_FRM_ID, PH_FRM_LEN, PH_PIXELS, PH_ROW_PAD, PH_TRAIL, PH_TICK_ID,
    PH_TICK_LEN, PH_TICK_DATA, PH_STOPPED
  } phase_t;

  logic          byte_valid_r;
  logic [7:0]    byte_r;
  phase_t        phase_r, phase_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [15:0]   stride_r, stride_nxt;
  logic [W-1:0]  width_r, width_nxt;
  logic [W-1:0]  height_r, height_nxt;
  logic [31:0]   blen_r, blen_nxt;
  logic [W-1:0]  rowpos_r, rowpos_nxt;
  logic [W-1:0]  rows_r, rows_nxt;
  logic [15:0]   held_r, held_nxt;
  logic [31:0]   skip_r, skip_nxt;
  logic [15:0]   frames_r, frames_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [UW-1:0] used_r;

  logic          fire;
  logic [63:0]   acc_upd;
  logic [3:0]    cnt_inc;
  logic [31:0]   bl_new;
  logic [31:0]   fin_bl;
  logic [31:0]   used32;
  logic          fin_more;
  logic [31:0]   fin_skip;
  logic [W-1:0]  effw;
  logic [W-2:0]  half_w;
  logic [W:0]    rb;
  logic [16:0]   stride17;
  logic [16:0]   rb17;
  logic [16:0]   pad17;
  logic          last_row;
  logic          row_end;
  logic [W-1:0]  rows_inc;
  logic [31:0]   skip_dec;
  logic [31:0]   bl_dec;
  logic [63:0]   tdata;
  logic [15:0]   frames_inc;
  logic [15:0]   limit;
  logic [7:0]    b0, b1;

  assign fire     = byte_valid_r && can_take;
  assign in_ready = !byte_valid_r || fire;

  assign acc_upd  = acc_r | ({56'd0, byte_r} << {cnt_r[2:0], 3'b000});
  assign cnt_inc  = cnt_r + 4'd1;
  assign bl_new   = acc_upd[31:0] - 32'd4;

  assign used32   = 32'(used_r);
  assign fin_bl   = (phase_r == PH_FRM_LEN) ? bl_new : blen_r;
  assign fin_more = fin_bl > used32;
  assign fin_skip = fin_bl - used32;

  assign half_w   = width_r[W-1:1];
  assign effw     = {half_w, 1'b0};
  assign rb       = (W+1)'(half_w) + ((W+1)'(half_w) << 1);
  assign stride17 = {1'b0, stride_r};
  assign rb17     = 17'(rb);
  assign pad17    = stride17 - rb17;

  assign last_row = ({1'b0, rows_r} + (W+1)'(1)) >= {1'b0, height_r};
  assign row_end  = ({1'b0, rowpos_r} + (W+1)'(2)) >= {1'b0, effw};
  assign rows_inc = rows_r + W'(1);

  assign skip_dec = skip_r - 32'(skip_r != 32'd0);
  assign bl_dec   = blen_r - 32'(blen_r != 32'd0);
  assign tdata    = (cnt_r < 4'(TICK_BYTES)) ? acc_upd : acc_r;

  assign frames_inc = (frames_r != 16'hFFFF) ? frames_r + 16'd1 : frames_r;
  assign limit      = (frames_to_take == 16'd0) ? 16'd1 : frames_to_take;

  assign b0 = held_r[7:0];
  assign b1 = held_r[15:8];

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    stride_nxt = stride_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    blen_nxt   = blen_r;
    rowpos_nxt = rowpos_r;
    rows_nxt   = rows_r;
    held_nxt   = held_r;
    skip_nxt   = skip_r;
    frames_nxt = frames_r;
    err_nxt    = err_r;
    res0       = '0;
    res1       = '0;
    push_n     = 2'd0;

    if (fire && err_r == pf12u_pkg::ERR_NONE) begin
      case (phase_r)
        PH_HDR_ID, PH_HDR_LEN, PH_STRIDE, PH_ENC, PH_CLOCK, PH_WIDTH, PH_HEIGHT,
        PH_FRM_ID, PH_FRM_LEN, PH_TICK_ID, PH_TICK_LEN: begin
          acc_nxt = acc_upd;
          cnt_nxt = cnt_inc;
          case (phase_r)
            PH_HDR_ID: begin
              if (cnt_inc >= 4'd4) begin
                acc_nxt   = '0;
                cnt_nxt   = '0;
                held_nxt  = {15'd0, acc_upd == 64'd2};
                phase_nxt = PH_HDR_LEN;
              end
            end
            PH_HDR_LEN: begin
              if (cnt_inc >= 4'd4) begin
                acc_nxt  = '0;
                cnt_nxt  = '0;
                held_nxt = '0;
                if (!held_r[0] || acc_upd != 64'd19) begin
                  err_nxt         = pf12u_pkg::ERR_HEADER;
                  phase_nxt       = PH_STOPPED;
                  res0.item_kind  = pf12u_pkg::KIND_ERROR;
                  res0.error_code = pf12u_pkg::ERR_HEADER;
                  res0.last_of_run = 1'b1;
                  push_n          = 2'd1;
                end else begin
                  phase_nxt = PH_STRIDE;
                end
              end
            end
            PH_STRIDE: begin
              if (cnt_inc >= 4'd2) begin
                acc_nxt    = '0;
                cnt_nxt    = '0;
                stride_nxt = acc_upd[15:0];
                phase_nxt  = PH_ENC;
              end
            end
            PH_ENC: begin
              acc_nxt = '0;
              cnt_nxt = '0;
              if (acc_upd[7:0] != encoding_code) begin
                err_nxt          = pf12u_pkg::ERR_ENCODING;
                phase_nxt        = PH_STOPPED;
                res0.item_kind   = pf12u_pkg::KIND_ERROR;
                res0.error_code  = pf12u_pkg::ERR_ENCODING;
                res0.last_of_run = 1'b1;
                push_n           = 2'd1;
              end else begin
                phase_nxt = PH_CLOCK;
              end
            end
            PH_CLOCK: begin
              if (cnt_inc >= 4'd8) begin
                acc_nxt   = '0;
                cnt_nxt   = '0;
                phase_nxt = PH_WIDTH;
              end
            end
            PH_WIDTH: begin
              if (cnt_inc >= 4'd2) begin
                acc_nxt   = '0;
                cnt_nxt   = '0;
                width_nxt = acc_upd[W-1:0];
                phase_nxt = PH_HEIGHT;
              end
            end
            PH_HEIGHT: begin
              if (cnt_inc >= 4'd2) begin
                acc_nxt    = '0;
                cnt_nxt    = '0;
                height_nxt = acc_upd[W-1:0];
                phase_nxt  = PH_FRM_ID;
              end
            end
            PH_FRM_ID: begin
              if (cnt_inc >= 4'd4) begin
                acc_nxt = '0;
                cnt_nxt = '0;
                if (acc_upd != 64'd0) begin
                  err_nxt          = pf12u_pkg::ERR_FRAME_ID;
                  phase_nxt        = PH_STOPPED;
                  res0.item_kind   = pf12u_pkg::KIND_ERROR;
                  res0.error_code  = pf12u_pkg::ERR_FRAME_ID;
                  res0.last_of_run = 1'b1;
                  push_n           = 2'd1;
                end else begin
                  phase_nxt = PH_FRM_LEN;
                end
              end
            end
            PH_FRM_LEN: begin
              if (cnt_inc >= 4'd4) begin
                acc_nxt    = '0;
                cnt_nxt    = '0;
                blen_nxt   = bl_new;
                rows_nxt   = '0;
                rowpos_nxt = '0;
                held_nxt   = '0;
                if (effw == '0 || height_r == '0) begin
                  // empty frame: straight to the trailing skip, or to the tick block if none
                  skip_nxt  = fin_more ? fin_skip : 32'd0;
                  phase_nxt = fin_more ? PH_TRAIL : PH_TICK_ID;
                end else begin
                  phase_nxt = PH_PIXELS;
                end
              end
            end
            PH_TICK_ID: begin
              if (cnt_inc >= 4'd4) begin
                acc_nxt = '0;
                cnt_nxt = '0;
                if (acc_upd != 64'd1) begin
                  err_nxt          = pf12u_pkg::ERR_TICK_ID;
                  phase_nxt        = PH_STOPPED;
                  res0.item_kind   = pf12u_pkg::KIND_ERROR;
                  res0.error_code  = pf12u_pkg::ERR_TICK_ID;
                  res0.last_of_run = 1'b1;
                  push_n           = 2'd1;
                end else begin
                  phase_nxt = PH_TICK_LEN;
                end
              end
            end
            default: begin
              // tick length
              if (cnt_inc >= 4'd4) begin
                acc_nxt  = '0;
                cnt_nxt  = '0;
                blen_nxt = bl_new;
                if (bl_new == 32'd0) begin
                  // empty tick data: stamp reads as zero
                  res0.item_kind   = pf12u_pkg::KIND_TICK;
                  res0.last_of_run = 1'b1;
                  push_n           = 2'd1;
                  frames_nxt       = frames_inc;
                  phase_nxt        = (frames_inc >= limit) ? PH_STOPPED : PH_FRM_ID;
                end else begin
                  phase_nxt = PH_TICK_DATA;
                end
              end
            end
          endcase
        end
        PH_PIXELS: begin
          if (cnt_r == 4'd0) begin
            held_nxt = {8'd0, byte_r};
            cnt_nxt  = 4'd1;
          end else if (cnt_r == 4'd1) begin
            held_nxt = {byte_r, held_r[7:0]};
            cnt_nxt  = 4'd2;
          end else begin
            cnt_nxt           = '0;
            held_nxt          = '0;
            res0.item_kind    = pf12u_pkg::KIND_PIXEL;
            res0.item_value   = {52'd0, b0, b1[3:0]};
            res1.item_kind    = pf12u_pkg::KIND_PIXEL;
            res1.item_value   = {52'd0, byte_r, b1[7:4]};
            res1.end_of_frame = last_row && row_end;
            res1.last_of_run  = 1'b1;
            push_n            = 2'd2;
            if (row_end) begin
              rowpos_nxt = '0;
              rows_nxt   = rows_inc;
              if (stride17 > rb17) begin
                skip_nxt  = 32'(pad17[15:0]);
                phase_nxt = PH_ROW_PAD;
              end else if (rows_inc >= height_r) begin
                acc_nxt   = '0;
                skip_nxt  = fin_more ? fin_skip : 32'd0;
                phase_nxt = fin_more ? PH_TRAIL : PH_TICK_ID;
              end else begin
                phase_nxt = PH_PIXELS;
              end
            end else begin
              rowpos_nxt = rowpos_r + W'(2);
            end
          end
        end
        PH_ROW_PAD: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            if (rows_r >= height_r) begin
              cnt_nxt   = '0;
              acc_nxt   = '0;
              skip_nxt  = fin_more ? fin_skip : 32'd0;
              phase_nxt = fin_more ? PH_TRAIL : PH_TICK_ID;
            end else begin
              phase_nxt = PH_PIXELS;
            end
          end
        end
        PH_TRAIL: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_nxt = PH_TICK_ID;
          end
        end
        PH_TICK_DATA: begin
          // bytes past the stamp width are only counted down
          if (cnt_r < 4'(TICK_BYTES)) begin
            acc_nxt = acc_upd;
            cnt_nxt = cnt_inc;
          end
          blen_nxt = bl_dec;
          if (bl_dec == 32'd0) begin
            res0.item_kind   = pf12u_pkg::KIND_TICK;
            res0.item_value  = tdata;
            res0.last_of_run = 1'b1;
            push_n           = 2'd1;
            acc_nxt          = '0;
            cnt_nxt          = '0;
            frames_nxt       = frames_inc;
            phase_nxt        = (frames_inc >= limit) ? PH_STOPPED : PH_FRM_ID;
          end
        end
        default: begin
          // stopped: byte dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
      phase_r      <= PH_HDR_ID;
      cnt_r        <= '0;
      acc_r        <= '0;
      stride_r     <= '0;
      width_r      <= '0;
      height_r     <= '0;
      blen_r       <= '0;
      rowpos_r     <= '0;
      rows_r       <= '0;
      held_r       <= '0;
      skip_r       <= '0;
      frames_r     <= '0;
      err_r        <= pf12u_pkg::ERR_NONE;
    end else begin
      if (in_ready) begin
        byte_valid_r <= in_valid;
      end
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      stride_r <= stride_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      blen_r   <= blen_nxt;
      rowpos_r <= rowpos_nxt;
      rows_r   <= rows_nxt;
      held_r   <= held_nxt;
      skip_r   <= skip_nxt;
      frames_r <= frames_nxt;
      err_r    <= err_nxt;
    end
  end

  // payload only; stride and height settle long before a frame length ends
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
    used_r <= UW'(stride_r) * UW'(height_r);
  end

endmodule

/* rtl/pf12u_out_fifo.sv */
// ---------------------------------------------------------------------------
// pf12u_out_fifo
// Result queue: takes up to two results per cycle, hands out one per
// transfer. The head entry drives the result ports.
// ---------------------------------------------------------------------------
`include "packed12_frame_stream_unpacker_assert.svh"

module pf12u_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  pf12u_pkg::result_t  res0,
  input  pf12u_pkg::result_t  res1,
  output logic                can_take,
  output logic                out_valid,
  input  logic                out_ready,
  output pf12u_pkg::result_t  out_res
);

  localparam int unsigned PW = pf12u_pkg::FIFO_PTR_W;
  localparam int unsigned CW = pf12u_pkg::FIFO_CNT_W;

  pf12u_pkg::result_t mem_r [pf12u_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for a full pixel pair
  assign can_take  = cnt_r <= CW'(pf12u_pkg::FIFO_DEPTH - 2);

  assign wr_ptr_nxt = wr_ptr_r + PW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign cnt_nxt    = cnt_r + CW'(push_n) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= res1;
    end
  end

  `PF12U_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(pf12u_pkg::FIFO_DEPTH))
  `PF12U_ASSERT_IMP(a_push_room, push_n != 2'd0, cnt_r <= CW'(pf12u_pkg::FIFO_DEPTH - 2))
  `PF12U_ASSERT_IMP(a_eof_is_last_pixel, out_valid && out_res.end_of_frame, out_res.last_of_run && out_res.item_kind == pf12u_pkg::KIND_PIXEL)

endmodule
